// ===== src/pls_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the positional list store.
// Used by every module of the block except pls_ram; depends on nothing.
package pls_pkg;

  localparam int DEPTH     = 64;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int DATA_W    = 32;
  localparam int POS_W     = 7;
  localparam int CMD_W     = 4;
  localparam int COUNT_W   = 7;
  localparam int STATUS_W  = 2;
  localparam int CMP_W     = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND     = 4'd0,
    CMD_PREPEND    = 4'd1,
    CMD_DROP_LAST  = 4'd2,
    CMD_DROP_FIRST = 4'd3,
    CMD_INSERT     = 4'd4,
    CMD_READ       = 4'd5,
    CMD_REMOVE     = 4'd6,
    CMD_OVERWRITE  = 4'd7,
    CMD_CLEAR      = 4'd8
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT_INS,
    S_PUT,
    S_SHIFT_REM,
    S_CAPTURE,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    TGT_POS,
    TGT_ZERO,
    TGT_COUNT
  } tgt_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     take;
    logic     decode;
    status_t  st_code;
    logic     load_ins;
    logic     load_rem;
    tgt_sel_t tgt_sel;
    logic     shift_ins;
    logic     shift_rem;
    logic     put;
    logic     write_pos;
    logic     read_pos;
    logic     capture;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     cnt_clr;
    logic     finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic full;
    logic empty;
    logic scan_done;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== src/pls_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stands alone; no package needed.
module pls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/pls_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the positional list store: command registers, entry RAM,
// shift pointer, count and the output register. Depends on pls_pkg, pls_ram.
module pls_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic [pls_pkg::S_TDATA_W-1:0]      s_tdata,
  input  logic [pls_pkg::CMD_W-1:0]          s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [pls_pkg::M_TDATA_W-1:0]      m_tdata,
  input  pls_pkg::ctrl_cmd_t                 cmd,
  output pls_pkg::dp_stat_t                  stat
);

  logic [pls_pkg::CMD_W-1:0]   cmd_r;
  logic [pls_pkg::DATA_W-1:0]  value_r;
  logic [pls_pkg::POS_W-1:0]   pos_r;
  logic [pls_pkg::CNT_W-1:0]   count_r;
  logic [pls_pkg::CNT_W-1:0]   tgt;
  logic [pls_pkg::CNT_W-1:0]   ptr;
  logic [pls_pkg::CNT_W-1:0]   lim;
  logic                        pend;
  logic [pls_pkg::ADDR_W-1:0]  pend_addr;
  logic [pls_pkg::DATA_W-1:0]  rd_r;
  pls_pkg::status_t            st_r;
  logic [pls_pkg::DATA_W-1:0]  out_value;
  logic [pls_pkg::COUNT_W-1:0] out_count;
  pls_pkg::status_t            out_status;

  logic [pls_pkg::CNT_W-1:0]   tgt_val;
  logic [pls_pkg::CNT_W-1:0]   ptr_dec;
  logic [pls_pkg::CNT_W-1:0]   ptr_inc;
  logic                        ptr_at_lim;
  logic                        ram_we;
  logic [pls_pkg::ADDR_W-1:0]  ram_waddr;
  logic [pls_pkg::DATA_W-1:0]  ram_wdata;
  logic [pls_pkg::ADDR_W-1:0]  ram_raddr;
  logic [pls_pkg::DATA_W-1:0]  ram_rdata;

  assign ptr_dec    = ptr - pls_pkg::CNT_W'(1);
  assign ptr_inc    = ptr + pls_pkg::CNT_W'(1);
  assign ptr_at_lim = (ptr == lim);

  always_comb begin
    case (cmd.tgt_sel)
      pls_pkg::TGT_ZERO:  tgt_val = '0;
      pls_pkg::TGT_COUNT: tgt_val = count_r;
      default:            tgt_val = pls_pkg::CNT_W'(pos_r);
    endcase
  end

  // Write port: pending shift move, placement of a new entry, or overwrite.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = ram_rdata;
    if (pend) begin
      ram_we = 1'b1;
    end else if (cmd.put) begin
      ram_we    = 1'b1;
      ram_waddr = tgt[pls_pkg::ADDR_W-1:0];
      ram_wdata = value_r;
    end else if (cmd.write_pos) begin
      ram_we    = 1'b1;
      ram_waddr = pos_r[pls_pkg::ADDR_W-1:0];
      ram_wdata = value_r;
    end
  end

  always_comb begin
    if (cmd.shift_ins) begin
      ram_raddr = ptr_dec[pls_pkg::ADDR_W-1:0];
    end else if (cmd.shift_rem) begin
      ram_raddr = ptr[pls_pkg::ADDR_W-1:0];
    end else begin
      ram_raddr = pos_r[pls_pkg::ADDR_W-1:0];
    end
  end

  pls_ram #(
    .WIDTH (pls_pkg::DATA_W),
    .DEPTH (pls_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.take && s_tvalid) begin
      cmd_r   <= s_tuser;
      value_r <= s_tdata[pls_pkg::DATA_W-1:0];
      pos_r   <= s_tdata[pls_pkg::DATA_W +: pls_pkg::POS_W];
    end
    if (cmd.load_ins || cmd.load_rem) begin
      tgt <= tgt_val;
    end
    if (cmd.decode) begin
      rd_r <= '0;
      st_r <= cmd.st_code;
    end else if (cmd.capture) begin
      rd_r <= ram_rdata;
    end
    if (cmd.finish) begin
      out_value  <= rd_r;
      out_count  <= pls_pkg::COUNT_W'(count_r);
      out_status <= st_r;
    end
  end

  // Shift pointer and pending move.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.load_ins) begin
      ptr  <= count_r;
      lim  <= tgt_val;
      pend <= 1'b0;
    end else if (cmd.load_rem) begin
      ptr  <= tgt_val + pls_pkg::CNT_W'(1);
      lim  <= count_r;
      pend <= 1'b0;
    end else if (cmd.shift_ins) begin
      pend <= !ptr_at_lim;
      if (!ptr_at_lim) begin
        ptr       <= ptr_dec;
        pend_addr <= ptr[pls_pkg::ADDR_W-1:0];
      end
    end else if (cmd.shift_rem) begin
      pend <= !ptr_at_lim;
      if (!ptr_at_lim) begin
        ptr       <= ptr_inc;
        pend_addr <= ptr_dec[pls_pkg::ADDR_W-1:0];
      end
    end else begin
      pend <= 1'b0;
    end
  end

  // Entry count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_r  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        count_r <= '0;
      end else if (cmd.cnt_inc) begin
        count_r <= count_r + pls_pkg::CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - pls_pkg::CNT_W'(1);
      end
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{(pls_pkg::M_TDATA_W - pls_pkg::DATA_W - pls_pkg::COUNT_W
                      - pls_pkg::STATUS_W){1'b0}},
                    out_status, out_count, out_value};

  assign stat.cmd        = pls_pkg::cmd_t'(cmd_r);
  assign stat.pos_gt_cnt = pls_pkg::CMP_W'(pos_r) > pls_pkg::CMP_W'(count_r);
  assign stat.pos_ge_cnt = pls_pkg::CMP_W'(pos_r) >= pls_pkg::CMP_W'(count_r);
  assign stat.full       = (count_r == pls_pkg::CNT_W'(pls_pkg::DEPTH));
  assign stat.empty      = (count_r == '0);
  assign stat.scan_done  = ptr_at_lim && !pend;
  assign stat.out_busy   = m_tvalid && !m_tready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_r <= pls_pkg::CNT_W'(pls_pkg::DEPTH))
    else $error("entry count exceeds depth");

  a_no_grow_full: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !stat.full)
    else $error("entry added to a full list");

  a_move_in_list: assert property (@(posedge clk) disable iff (rst)
    pend |-> pls_pkg::CNT_W'(pend_addr) <= count_r)
    else $error("shift move lands beyond the list");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !stat.out_busy)
    else $error("result overwrites one not yet taken");

  a_shift_no_overlap: assert property (@(posedge clk) disable iff (rst)
    pend |-> !cmd.put && !cmd.write_pos)
    else $error("RAM write port claimed twice");

endmodule

// ===== src/pls_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the positional list store: sequences each command over the
// datapath. Depends on pls_pkg.
module pls_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  pls_pkg::dp_stat_t  stat,
  output pls_pkg::ctrl_cmd_t cmd
);

  pls_pkg::state_t state;
  pls_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pls_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pls_pkg::S_IDLE: begin
        if (s_tvalid) state_next = pls_pkg::S_DECODE;
      end
      pls_pkg::S_DECODE: begin
        state_next = pls_pkg::S_DONE;
        case (stat.cmd)
          pls_pkg::CMD_APPEND, pls_pkg::CMD_PREPEND: begin
            if (!stat.full) state_next = pls_pkg::S_SHIFT_INS;
          end
          pls_pkg::CMD_INSERT: begin
            if (!stat.pos_gt_cnt && !stat.full) state_next = pls_pkg::S_SHIFT_INS;
          end
          pls_pkg::CMD_DROP_FIRST: begin
            if (!stat.empty) state_next = pls_pkg::S_SHIFT_REM;
          end
          pls_pkg::CMD_REMOVE: begin
            if (!stat.pos_ge_cnt) state_next = pls_pkg::S_SHIFT_REM;
          end
          pls_pkg::CMD_READ: begin
            if (!stat.pos_ge_cnt) state_next = pls_pkg::S_CAPTURE;
          end
          default: state_next = pls_pkg::S_DONE;
        endcase
      end
      pls_pkg::S_SHIFT_INS: begin
        if (stat.scan_done) state_next = pls_pkg::S_PUT;
      end
      pls_pkg::S_PUT:     state_next = pls_pkg::S_DONE;
      pls_pkg::S_SHIFT_REM: begin
        if (stat.scan_done) state_next = pls_pkg::S_DONE;
      end
      pls_pkg::S_CAPTURE: state_next = pls_pkg::S_DONE;
      pls_pkg::S_DONE: begin
        if (!stat.out_busy) state_next = pls_pkg::S_IDLE;
      end
      default: state_next = pls_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.st_code = pls_pkg::ST_OK;
    cmd.tgt_sel = pls_pkg::TGT_POS;
    case (state)
      pls_pkg::S_IDLE: cmd.take = 1'b1;
      pls_pkg::S_DECODE: begin
        cmd.decode = 1'b1;
        case (stat.cmd)
          pls_pkg::CMD_APPEND: begin
            cmd.tgt_sel = pls_pkg::TGT_COUNT;
            if (stat.full) cmd.st_code = pls_pkg::ST_FULL;
            else cmd.load_ins = 1'b1;
          end
          pls_pkg::CMD_PREPEND: begin
            cmd.tgt_sel = pls_pkg::TGT_ZERO;
            if (stat.full) cmd.st_code = pls_pkg::ST_FULL;
            else cmd.load_ins = 1'b1;
          end
          pls_pkg::CMD_INSERT: begin
            if (stat.pos_gt_cnt) cmd.st_code = pls_pkg::ST_RANGE;
            else if (stat.full) cmd.st_code = pls_pkg::ST_FULL;
            else cmd.load_ins = 1'b1;
          end
          pls_pkg::CMD_DROP_LAST: begin
            if (stat.empty) cmd.st_code = pls_pkg::ST_RANGE;
            else cmd.cnt_dec = 1'b1;
          end
          pls_pkg::CMD_DROP_FIRST: begin
            cmd.tgt_sel = pls_pkg::TGT_ZERO;
            if (stat.empty) cmd.st_code = pls_pkg::ST_RANGE;
            else cmd.load_rem = 1'b1;
          end
          pls_pkg::CMD_REMOVE: begin
            if (stat.pos_ge_cnt) cmd.st_code = pls_pkg::ST_RANGE;
            else cmd.load_rem = 1'b1;
          end
          pls_pkg::CMD_READ: begin
            if (stat.pos_ge_cnt) cmd.st_code = pls_pkg::ST_RANGE;
            else cmd.read_pos = 1'b1;
          end
          pls_pkg::CMD_OVERWRITE: begin
            if (stat.pos_ge_cnt) cmd.st_code = pls_pkg::ST_RANGE;
            else cmd.write_pos = 1'b1;
          end
          pls_pkg::CMD_CLEAR: cmd.cnt_clr = 1'b1;
          default: cmd.st_code = pls_pkg::ST_RANGE;
        endcase
      end
      pls_pkg::S_SHIFT_INS: cmd.shift_ins = 1'b1;
      pls_pkg::S_PUT: begin
        cmd.put     = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      pls_pkg::S_SHIFT_REM: begin
        cmd.shift_rem = 1'b1;
        cmd.cnt_dec   = stat.scan_done;
      end
      pls_pkg::S_CAPTURE: cmd.capture = 1'b1;
      pls_pkg::S_DONE: cmd.finish = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

  // No transfer is taken while reset holds the controller in idle.
  assign s_tready = cmd.take && !rst;

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == pls_pkg::S_DECODE)
    else $error("accepted transfer not decoded");

  a_put_after_scan: assert property (@(posedge clk) disable iff (rst)
    state == pls_pkg::S_PUT |-> $past(state) == pls_pkg::S_SHIFT_INS)
    else $error("entry placed without a shift pass");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == pls_pkg::S_IDLE)
    else $error("result issued twice for one command");

endmodule

// ===== src/positional_list_store.sv =====
`timescale 1ns / 1ps
// Top level of the positional list store: an ordered list of signed values
// with insert, remove, read and overwrite by position. Depends on pls_pkg,
// pls_ctrl, pls_dp (which holds the pls_ram entry store).
//
//   Channel  Dir  Handshake          Contents
//   s_*      in   s_tvalid/s_tready  s_tuser: cmd; s_tdata: value, position
//   m_*      out  m_tvalid/m_tready  m_tdata: read_value, count, status
//
// Sequencing: one command per transfer, one result per command. A read passes
// through an extra capture step. An insert (and append or prepend) and a remove
// (and drop first) take longer the more entries lie at or above the position,
// because every moved entry goes through the single read and single write
// port of the entry RAM. The worst case is an insert at position zero into a
// list of DEPTH - 1.
// Reset: rst clears the count and the controller; the entry RAM is not
// cleared, since entries at or above the count are never read.
// Stalls: a finished result sits in the output register; the next command
// may be accepted meanwhile, and its own result waits until that is taken.
module positional_list_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [31:0] value, [38:32] position, [39] zero fill
  input  logic [pls_pkg::S_TDATA_W-1:0] s_tdata,
  // [3:0] cmd
  input  logic [pls_pkg::CMD_W-1:0]     s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [31:0] read_value, [38:32] count, [40:39] status, [47:41] zero fill
  output logic [pls_pkg::M_TDATA_W-1:0] m_tdata
);

  pls_pkg::ctrl_cmd_t cmd;
  pls_pkg::dp_stat_t  stat;

  // The controller walks each command through decode, an optional shift pass
  // and placement or read capture on the RAM, and the result hand-off.
  pls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the count, the entries and the output register.
  pls_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// ===== verif/pls_checker.sv =====
`timescale 1ns / 1ps
// Checker for the positional list store: keeps a shadow copy of the list, predicts the
// result of every accepted command and compares it with what the block returns.
// Depends on pls_pkg for the command and status codes and the field widths.
module pls_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  // [31:0] value, [38:32] position, [39] zero fill
  input  logic [pls_pkg::S_TDATA_W-1:0] s_tdata,
  // [3:0] cmd
  input  logic [pls_pkg::CMD_W-1:0]     s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  // [31:0] read_value, [38:32] count, [40:39] status, [47:41] zero fill
  input  logic [pls_pkg::M_TDATA_W-1:0] m_tdata,
  output int                            mismatches,
  output int                            outstanding,
  output int                            list_len,
  output int                            cmds_seen,
  output int                            results_checked,
  output int                            full_hits,
  output int                            range_hits
);
  import pls_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0]  read_value;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } list_result_t;

  logic [DATA_W-1:0] shadow_slots [DEPTH];
  int                shadow_len;
  list_result_t      awaited_results [$];
  int                errs, n_cmds, n_checked, n_full, n_range;

  // Moves entries at and above pos up by one and stores v at pos.
  task automatic open_gap(input int pos, input logic [DATA_W-1:0] v);
    for (int i = shadow_len; i > pos; i--) shadow_slots[i] = shadow_slots[i-1];
    shadow_slots[pos] = v;
    shadow_len++;
  endtask

  // Moves entries above pos down by one, dropping the entry at pos.
  task automatic close_gap(input int pos);
    for (int i = pos; i + 1 < shadow_len; i++) shadow_slots[i] = shadow_slots[i+1];
    shadow_len--;
  endtask

  task automatic apply_list_cmd(input logic [CMD_W-1:0] code, input logic [DATA_W-1:0] v,
                                input logic [POS_W-1:0] p, output list_result_t r);
    int pos;
    pos          = int'(p);
    r.read_value = '0;
    r.status     = ST_OK;
    case (code)
      CMD_APPEND, CMD_PREPEND: begin
        if (shadow_len >= DEPTH) r.status = ST_FULL;
        else open_gap((code == CMD_APPEND) ? shadow_len : 0, v);
      end
      CMD_DROP_LAST: begin
        if (shadow_len == 0) r.status = ST_RANGE;
        else shadow_len--;
      end
      CMD_DROP_FIRST: begin
        if (shadow_len == 0) r.status = ST_RANGE;
        else close_gap(0);
      end
      CMD_INSERT: begin
        // The range check wins over the full check.
        if (pos > shadow_len) r.status = ST_RANGE;
        else if (shadow_len >= DEPTH) r.status = ST_FULL;
        else open_gap(pos, v);
      end
      CMD_READ: begin
        if (pos >= shadow_len) r.status = ST_RANGE;
        else r.read_value = shadow_slots[pos];
      end
      CMD_REMOVE: begin
        if (pos >= shadow_len) r.status = ST_RANGE;
        else close_gap(pos);
      end
      CMD_OVERWRITE: begin
        if (pos >= shadow_len) r.status = ST_RANGE;
        else shadow_slots[pos] = v;
      end
      CMD_CLEAR: shadow_len = 0;
      default: r.status = ST_RANGE;
    endcase
    r.count = COUNT_W'(shadow_len);
  endtask

  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (rst) begin
      awaited_results.delete();
      shadow_len = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_list_cmd(s_tuser, s_tdata[31:0], s_tdata[38:32], want);
        awaited_results.insert(awaited_results.size(), want);
        n_cmds++;
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_RANGE) n_range++;
      end
      if (m_tvalid && m_tready) begin
        got.read_value = m_tdata[31:0];
        got.count      = m_tdata[38:32];
        got.status     = status_t'(m_tdata[40:39]);
        if (awaited_results.size() == 0) begin
          $error("result transfer with no command outstanding: read_value %0d, count %0d",
                 $signed(got.read_value), got.count);
          errs++;
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          n_checked++;
          if (got.read_value !== want.read_value) begin
            $error("read_value mismatch: expected %0d, actual %0d",
                   $signed(want.read_value), $signed(got.read_value));
            errs++;
          end
          if (got.count !== want.count) begin
            $error("count mismatch: expected %0d, actual %0d", want.count, got.count);
            errs++;
          end
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            errs++;
          end
        end
      end
    end
    mismatches      <= errs;
    outstanding     <= awaited_results.size();
    list_len        <= shadow_len;
    cmds_seen       <= n_cmds;
    results_checked <= n_checked;
    full_hits       <= n_full;
    range_hits      <= n_range;
  end

endmodule

// ===== verif/positional_list_store_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the positional list store: drives commands, throttles the result
// stream and gives the verdict. Depends on pls_pkg, pls_checker and the block itself.
module positional_list_store_tb;
  import pls_pkg::*;

  localparam int                RAND_ITEMS    = 600;
  localparam int                HOLD_CYCLES   = 400;
  localparam int                STALL_LIMIT   = 3000;
  localparam int                DRAIN_CYCLES  = 80;
  // Command codes the block does not define; they must be rejected.
  localparam logic [CMD_W-1:0]  CMD_UNUSED_LO = 4'd9;
  localparam logic [CMD_W-1:0]  CMD_UNUSED_HI = 4'd15;

  logic                 clk;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic [CMD_W-1:0]     s_tuser  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  int   mismatches, outstanding, list_len;
  int   cmds_seen, results_checked, full_hits, range_hits;
  int   tx_idle_pct = 17;
  int   rx_idle_pct = 58;
  logic hold_go     = 1'b0;
  int   quiet_cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  positional_list_store i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  pls_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .list_len        (list_len),
    .cmds_seen       (cmds_seen),
    .results_checked (results_checked),
    .full_hits       (full_hits),
    .range_hits      (range_hits)
  );

  // Offers one command, after a random number of idle cycles, and returns at the
  // edge where the transfer happens. Valid stays high so back-to-back commands
  // leave no gap unless the idle draw asks for one.
  task automatic send(input logic [CMD_W-1:0] code, input logic [DATA_W-1:0] v,
                      input logic [POS_W-1:0] p);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= code;
    s_tdata  <= {1'b0, p, v};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Mostly random values, with the signed extremes, zero and minus one mixed in.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Mostly in-range positions, but also exactly the count, anything above it,
  // and the top of the 7-bit field.
  function automatic logic [POS_W-1:0] pick_pos(input int len, input logic [CMD_W-1:0] code);
    int hi;
    int r;
    hi = (code == CMD_INSERT) ? len : len - 1;
    if (hi < 0) hi = 0;
    r = $urandom_range(99);
    if (r < 65) return POS_W'($urandom_range(hi, 0));
    else if (r < 75) return POS_W'(len);
    else if (r < 95) return POS_W'($urandom_range(127, len));
    else return 7'd127;
  endfunction

  // One random command. The mix depends on the mode: two growing modes push the
  // list toward full, a churn mode uses every code, and a shrinking mode drains.
  // The list length seen here may trail the last accepted command by one.
  task automatic random_command(input int mode);
    logic [CMD_W-1:0] code;
    int               r;
    r = $urandom_range(99);
    case (mode)
      0, 1: begin
        if (r < 30) code = CMD_APPEND;
        else if (r < 50) code = CMD_PREPEND;
        else if (r < 80) code = CMD_INSERT;
        else if (r < 90) code = CMD_READ;
        else code = CMD_OVERWRITE;
      end
      2: begin
        if (r < 3) code = CMD_CLEAR;
        else if (r < 8) code = CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
        else code = CMD_W'($urandom_range(CMD_OVERWRITE, CMD_APPEND));
      end
      default: begin
        if (r < 20) code = CMD_DROP_LAST;
        else if (r < 35) code = CMD_DROP_FIRST;
        else if (r < 70) code = CMD_REMOVE;
        else if (r < 88) code = CMD_READ;
        else code = CMD_OVERWRITE;
      end
    endcase
    send(code, pick_value(), pick_pos(list_len, code));
  endtask

  // Result side. Random back-pressure at the current rate, except once: a long
  // hold-off counted here, during which the sender keeps offering commands until
  // the block's output register is full and it stops accepting.
  initial begin : result_sink
    logic hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rst) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: ends the run after too many cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int mode;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on a short list: empty-list rejects, inserts at both ends
    // and at the count, reads at and past the end, the one-entry drop-last,
    // undefined codes and a clear of an empty list.
    send(CMD_CLEAR,      '0, '0);
    send(CMD_DROP_LAST,  '0, '0);
    send(CMD_DROP_FIRST, '0, '0);
    send(CMD_READ,       '0, '0);
    send(CMD_REMOVE,     '0, '0);
    send(CMD_OVERWRITE,  32'h1234_5678, '0);
    send(CMD_INSERT,     32'h1111_1111, 7'd1);
    send(CMD_INSERT,     32'h8000_0000, 7'd0);
    send(CMD_APPEND,     32'h7FFF_FFFF, '0);
    send(CMD_PREPEND,    32'hFFFF_FFFF, '0);
    send(CMD_INSERT,     32'h5A5A_5A5A, 7'd3);
    send(CMD_READ,       '0, 7'd0);
    send(CMD_READ,       '0, 7'd3);
    send(CMD_READ,       '0, 7'd4);
    send(CMD_OVERWRITE,  32'h0000_0000, 7'd1);
    send(CMD_READ,       '0, 7'd1);
    send(CMD_REMOVE,     '0, 7'd1);
    send(CMD_DROP_FIRST, '0, '0);
    send(CMD_DROP_LAST,  '0, '0);
    send(CMD_DROP_LAST,  '0, '0);
    send(CMD_READ,       '0, 7'd0);
    send(CMD_UNUSED_LO,  32'hA5A5_A5A5, 7'd0);
    send(CMD_UNUSED_HI,  32'h5A5A_5A5A, 7'd127);
    send(CMD_READ,       '0, 7'd127);
    send(CMD_CLEAR,      '0, 7'd127);

    // Fill to capacity, then poke at the full list: every add is refused, an
    // insert past the count is refused for range first, and shifts run over
    // the whole depth.
    for (int n = 0; n < DEPTH; n++) send(CMD_APPEND, pick_value(), POS_W'($urandom_range(127)));
    send(CMD_APPEND,     pick_value(), '0);
    send(CMD_PREPEND,    pick_value(), '0);
    send(CMD_INSERT,     pick_value(), 7'd0);
    send(CMD_INSERT,     pick_value(), 7'd64);
    send(CMD_INSERT,     pick_value(), 7'd65);
    send(CMD_INSERT,     pick_value(), 7'd127);
    send(CMD_READ,       '0, 7'd63);
    send(CMD_READ,       '0, 7'd64);
    send(CMD_OVERWRITE,  32'h8000_0000, 7'd63);
    send(CMD_READ,       '0, 7'd63);
    send(CMD_REMOVE,     '0, 7'd0);
    send(CMD_INSERT,     pick_value(), 7'd0);
    send(CMD_REMOVE,     '0, 7'd63);
    send(CMD_INSERT,     pick_value(), 7'd63);
    send(CMD_DROP_FIRST, '0, '0);
    send(CMD_PREPEND,    pick_value(), '0);
    send(CMD_DROP_LAST,  '0, '0);

    // Random part in three throttling phases: slow receiver, slow sender, none.
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k == RAND_ITEMS / 3) begin
        tx_idle_pct = 58;
        rx_idle_pct <= 17;
      end
      if (k == 2 * RAND_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      if (k == 60) hold_go <= 1'b1;
      mode = (k / 50) % 4;
      random_command(mode);
    end
    s_tvalid <= 1'b0;

    // The checker's counters are registered, so let the last transfer land
    // before waiting for the outstanding results.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands and compared %0d results on a list of up to %0d entries;",
             cmds_seen, results_checked, DEPTH);
    $display("%0d commands met a full list and %0d were refused for range or an empty list.",
             full_hits, range_hits);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
